>>> hdl/tdr_pkg.sv
// Shared types and constants of the trajectory distance rank core.
// No dependencies; imported by the top level, the checker and the testbench.
`default_nettype none

package tdr_pkg;

	localparam int FLOW_W    = 24;   // input flow, signed Q15.8
	localparam int REL_W     = 25;   // baseline-relative flow
	localparam int OPND_W    = 27;   // difference fed to the squarer
	localparam int RAD_W     = 2 * OPND_W;
	localparam int ROOT_W    = OPND_W;
	localparam int SUM_W     = 40;
	localparam int DIST_W    = 31;
	localparam int LEN_W     = 7;
	localparam int ERR_W     = 31;
	localparam int METHOD_W  = 2;
	localparam int MAX_FRAMES_DEF = 64;

	localparam logic [1:0] OP_BASE   = 2'd0;
	localparam logic [1:0] OP_FRAME  = 2'd1;
	localparam logic [1:0] OP_CLOSE  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] METHOD_FINAL = 2'd0;
	localparam logic [1:0] METHOD_ACCUM = 2'd1;
	localparam logic [1:0] METHOD_ADJ   = 2'd2;

	localparam logic [1:0] V_REJECT = 2'd0;
	localparam logic [1:0] V_OTHER  = 2'd1;
	localparam logic [1:0] V_OWN    = 2'd2;
	localparam logic [1:0] V_EQUAL  = 2'd3;

	localparam logic CFG_METHOD    = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

endpackage

`default_nettype wire

>>> hdl/tdr_isqrt.sv
// Iterative integer square root, one result bit per cycle (floor of root).
// Standalone; the root width is given as a parameter.
`default_nettype none

module tdr_isqrt #(
	parameter int RW = 27
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [2*RW-1:0] radicand,
	output logic                 done,
	output logic [RW-1:0]        root
);
	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW+2:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [RW+2:0]   rem_sh;
	logic [RW+2:0]   trial;
	logic            ge;

	assign rem_sh = {rem_q[RW:0], rad_q[2*RW-1:2*RW-2]};
	assign trial  = {1'b0, root, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= busy_q && !go && (cnt_q == CW'(1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q <= radicand;
			rem_q <= '0;
			root  <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[2*RW-3:0], 2'b00};
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
			root  <= {root[RW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

>>> hdl/tdr_div.sv
// Restoring divider, one quotient bit per cycle, truncating.
// Standalone; parameters give dividend and divisor widths.
`default_nettype none

module tdr_div #(
	parameter int NW = 40,
	parameter int DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   rsh;
	logic          ge;

	assign rsh = {rem_q, quo[NW-1]};
	assign ge  = rsh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= busy_q && !go && (cnt_q == CW'(1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(rsh - {1'b0, den_q}) : rsh[DW-1:0];
			quo   <= {quo[NW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

>>> hdl/trajectory_distance_rank_core.sv
// Top level of the trajectory distance rank core: sequencer, state and shared
// squarer, driving the tdr_isqrt and tdr_div units. Depends on tdr_pkg.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: opcode; tdata: flows, lengths, errors
// m_*       out  m_tvalid/m_tready    tuser: verdict; tdata: distance_value
// cfg_*     in   cfg_wr_en            cfg_index selects register, cfg_data value
//
// A baseline item loads the baseline flows and clears the span state. A frame
// item runs one root in the final-frame method, a root then a 40-bit divide in
// the accumulated method and two roots with adjacent increments; the iterative
// root and divide units give one bit per cycle. A close item runs a divide
// unless the method is accumulated or the span is zero. Reset clears the
// sequencer, configuration, span and handshake state, not the payload registers.
// The output register lets a new item enter while a result waits; only a close
// item that finds the output register still full stalls on m_tready.
`default_nettype none

module trajectory_distance_rank_core
	import tdr_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// own_dx, own_dy, other_dx, other_dy, span_length, own_extrap_len,
	// other_extrap_len, own_fit_error, other_fit_error, zero pad
	input  wire logic [183:0] s_tdata,
	// opcode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// distance_value, zero pad
	output logic [31:0]       m_tdata,
	// verdict
	output logic [1:0]        m_tuser,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [30:0]  cfg_data
);
	localparam int FIW = $clog2(MAX_FRAMES + 1);
	localparam int DVW = (FIW > LEN_W) ? FIW : LEN_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_OPS, ST_SQX, ST_SQY, ST_ADD, ST_ROOT, ST_POST,
		ST_FDIV, ST_FIN, ST_CLOSE, ST_CDIV, ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration.
	logic [METHOD_W-1:0] method_q;
	logic [DIST_W-1:0]   thr_q;

	// Span state.
	logic signed [FLOW_W-1:0] box_q, boy_q, bhx_q, bhy_q;
	logic signed [REL_W-1:0]  lox_q, loy_q, lhx_q, lhy_q;
	logic signed [REL_W-1:0]  ox_q, oy_q, hx_q, hy_q;
	logic [SUM_W-1:0]         sum_q;
	logic [ROOT_W-1:0]        lnorm_q;
	logic [FIW-1:0]           fidx_q;

	// Close item fields.
	logic [LEN_W-1:0] span_q, olen_q, hlen_q;
	logic [ERR_W-1:0] oerr_q, herr_q;
	logic [SUM_W-1:0] dist_q;
	logic             rej_q;

	// Shared squarer and unit handshakes.
	logic signed [OPND_W-1:0] opa_q, opb_q, mul_in;
	logic signed [RAD_W-1:0]  prod;
	logic [RAD_W-1:0]         sqa_q, sqb_q;
	logic                     phase_q;
	logic                     sq_go_q, div_go_q;
	logic [RAD_W-1:0]         sq_rad_q;
	logic [SUM_W-1:0]         div_num_q;
	logic [DVW-1:0]           div_den_q;
	logic                     sq_done, div_done;
	logic [ROOT_W-1:0]        root;
	logic [SUM_W-1:0]         quo;

	// Input field views.
	logic [1:0]               in_op;
	logic signed [FLOW_W-1:0] in_ox, in_oy, in_hx, in_hy;

	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     addend;
	logic [SUM_W-1:0]     sum_sat;
	logic [DIST_W-1:0]    dist_sat;
	logic [1:0]           verdict;

	assign in_op = s_tuser;
	assign in_ox = s_tdata[23:0];
	assign in_oy = s_tdata[47:24];
	assign in_hx = s_tdata[71:48];
	assign in_hy = s_tdata[95:72];

	assign s_tready = (state_q == ST_IDLE);

	// One multiplier, shared by both squares of both distances.
	assign mul_in = (state_q == ST_SQX) ? opa_q : opb_q;
	assign prod   = mul_in * mul_in;

	// Saturating accumulate of whichever unit finished last.
	assign addend  = (state_q == ST_FDIV) ? quo : SUM_W'(root);
	assign sum_add = {1'b0, sum_q} + {1'b0, addend};
	assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

	assign dist_sat = (dist_q > SUM_W'({DIST_W{1'b1}})) ? '1 : dist_q[DIST_W-1:0];

	always_comb begin
		if (rej_q || (dist_sat > thr_q)) begin
			verdict = V_REJECT;
		end else if (olen_q < hlen_q) begin
			verdict = V_OTHER;
		end else if (olen_q > hlen_q) begin
			verdict = V_OWN;
		end else if (oerr_q > herr_q) begin
			verdict = V_OTHER;
		end else if (oerr_q < herr_q) begin
			verdict = V_OWN;
		end else begin
			verdict = V_EQUAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_ADJ;
			thr_q    <= DIST_W'(256);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_METHOD:    method_q <= cfg_data[METHOD_W-1:0];
				CFG_THRESHOLD: thr_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			box_q     <= '0;
			boy_q     <= '0;
			bhx_q     <= '0;
			bhy_q     <= '0;
			lox_q     <= '0;
			loy_q     <= '0;
			lhx_q     <= '0;
			lhy_q     <= '0;
			sum_q     <= '0;
			lnorm_q   <= '0;
			fidx_q    <= '0;
			phase_q   <= 1'b0;
			sq_go_q   <= 1'b0;
			div_go_q  <= 1'b0;
			rej_q     <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			// Start pulses for the root and divide units.
			sq_go_q  <= (state_q == ST_ADD);
			div_go_q <= ((state_q == ST_POST) && !phase_q && (method_q == METHOD_ACCUM))
				|| ((state_q == ST_CLOSE) && (method_q != METHOD_ACCUM) && (span_q != '0));
			if ((state_q == ST_EMIT) && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (in_op)
							OP_BASE: begin
								box_q   <= in_ox;
								boy_q   <= in_oy;
								bhx_q   <= in_hx;
								bhy_q   <= in_hy;
								lox_q   <= '0;
								loy_q   <= '0;
								lhx_q   <= '0;
								lhy_q   <= '0;
								sum_q   <= '0;
								lnorm_q <= '0;
								fidx_q  <= '0;
							end
							OP_FRAME: begin
								if (fidx_q < FIW'(MAX_FRAMES)) begin
									state_q <= ST_OPS;
								end
							end
							OP_CLOSE: begin
								state_q <= ST_CLOSE;
							end
							default: ;
						endcase
					end
				end
				ST_OPS: begin
					phase_q <= 1'b0;
					state_q <= ST_SQX;
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (phase_q) begin
						sum_q   <= sum_sat;
						state_q <= ST_FIN;
					end else begin
						lnorm_q <= root;
						if (method_q == METHOD_ACCUM) begin
							state_q <= ST_FDIV;
						end else if (method_q == METHOD_FINAL) begin
							state_q <= ST_FIN;
						end else begin
							phase_q <= 1'b1;
							state_q <= ST_SQX;
						end
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						sum_q   <= sum_sat;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					lox_q   <= ox_q;
					loy_q   <= oy_q;
					lhx_q   <= hx_q;
					lhy_q   <= hy_q;
					fidx_q  <= fidx_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLOSE: begin
					// A zero span rejects, except in the accumulated method.
					rej_q <= (method_q != METHOD_ACCUM) && (span_q == '0);
					if ((method_q == METHOD_ACCUM) || (span_q == '0)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						lox_q    <= '0;
						loy_q    <= '0;
						lhx_q    <= '0;
						lhy_q    <= '0;
						sum_q    <= '0;
						lnorm_q  <= '0;
						fidx_q   <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ox_q   <= REL_W'(in_ox) - REL_W'(box_q);
			oy_q   <= REL_W'(in_oy) - REL_W'(boy_q);
			hx_q   <= REL_W'(in_hx) - REL_W'(bhx_q);
			hy_q   <= REL_W'(in_hy) - REL_W'(bhy_q);
			span_q <= s_tdata[102:96];
			olen_q <= s_tdata[109:103];
			hlen_q <= s_tdata[116:110];
			oerr_q <= s_tdata[147:117];
			herr_q <= s_tdata[178:148];
		end
		case (state_q)
			ST_OPS: begin
				opa_q <= OPND_W'(ox_q) - OPND_W'(hx_q);
				opb_q <= OPND_W'(oy_q) - OPND_W'(hy_q);
			end
			ST_POST: begin
				// Increment of each trajectory since the previous frame.
				opa_q <= (OPND_W'(ox_q) - OPND_W'(lox_q)) - (OPND_W'(hx_q) - OPND_W'(lhx_q));
				opb_q <= (OPND_W'(oy_q) - OPND_W'(loy_q)) - (OPND_W'(hy_q) - OPND_W'(lhy_q));
				div_num_q <= SUM_W'(root);
				div_den_q <= DVW'(fidx_q) + 1'b1;
			end
			ST_SQX: sqa_q <= prod;
			ST_SQY: sqb_q <= prod;
			ST_ADD: sq_rad_q <= sqa_q + sqb_q;
			ST_CLOSE: begin
				dist_q    <= ((method_q != METHOD_ACCUM) && (span_q == '0)) ?
					SUM_W'({DIST_W{1'b1}}) : sum_q;
				div_num_q <= (method_q == METHOD_FINAL) ? SUM_W'(lnorm_q) : sum_q;
				div_den_q <= DVW'(span_q);
			end
			ST_CDIV: begin
				if (div_done) begin
					dist_q <= quo;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {1'b0, dist_sat};
					m_tuser <= verdict;
				end
			end
			default: ;
		endcase
	end

	tdr_isqrt #(
		.RW(ROOT_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go_q),
		.radicand (sq_rad_q),
		.done     (sq_done),
		.root     (root)
	);

	tdr_div #(
		.NW(SUM_W),
		.DW(DVW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (quo)
	);

	// The frame counter never passes capacity.
	a_fidx_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q <= FIW'(MAX_FRAMES))
		else $error("frame index beyond capacity");

	// The divider is never started with a zero divisor.
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (div_den_q != '0))
		else $error("divide by zero started");

	// A distance over the threshold always comes out rejected.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[30:0] > thr_q)) |-> (m_tuser == V_REJECT))
		else $error("distance over threshold not rejected");

endmodule

`default_nettype wire

>>> verif/trajectory_distance_rank_checker.sv
// Checker for the trajectory distance rank core: watches both stream channels
// and the register port, predicts every result and compares. Depends on tdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_distance_rank_checker
	import tdr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [183:0] s_tdata,
	input  wire logic [1:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [31:0]  m_tdata,
	input  wire logic [1:0]   m_tuser,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [30:0]  cfg_data,
	output int                error_count,
	output int                pending_count
);

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [1:0]        verdict;
	} rank_t;

	rank_t rank_queue[$];

	logic [1:0]  method;
	logic [30:0] threshold;
	longint      base_ox, base_oy, base_hx, base_hy;
	longint      prev_ox, prev_oy, prev_hx, prev_hy;
	longint unsigned dist_sum, final_norm;
	int          frames;

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= r + bit_v) begin
				n -= r + bit_v;
				r = (r >> 1) + bit_v;
			end else begin
				r >>= 1;
			end
			bit_v >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned vec_len(longint a, longint b);
		return floor_root(longint'(a * a) + longint'(b * b));
	endfunction

	function automatic longint flow(logic [183:0] d, int k);
		return longint'($signed(d[k*24 +: 24]));
	endfunction

	task automatic add_to_sum(longint unsigned v);
		dist_sum += v;
		if (dist_sum > 64'hFF_FFFF_FFFF) dist_sum = 64'hFF_FFFF_FFFF;
	endtask

	task automatic clear_span();
		prev_ox = 0; prev_oy = 0; prev_hx = 0; prev_hy = 0;
		dist_sum = 0; final_norm = 0; frames = 0;
	endtask

	task automatic take_item(logic [1:0] op, logic [183:0] d);
		longint ox, oy, hx, hy;
		longint unsigned norm, dist_v;
		logic [6:0] span, own_len, oth_len;
		logic [30:0] own_err, oth_err;
		rank_t r;
		bit reject;
		span = d[96 +: 7]; own_len = d[103 +: 7]; oth_len = d[110 +: 7];
		own_err = d[117 +: 31]; oth_err = d[148 +: 31];
		reject = 0;
		if (op == OP_BASE) begin
			base_ox = flow(d, 0); base_oy = flow(d, 1);
			base_hx = flow(d, 2); base_hy = flow(d, 3);
			clear_span();
		end else if (op == OP_FRAME) begin
			if (frames < MAX_FRAMES_DEF) begin
				ox = flow(d, 0) - base_ox; oy = flow(d, 1) - base_oy;
				hx = flow(d, 2) - base_hx; hy = flow(d, 3) - base_hy;
				norm = vec_len(ox - hx, oy - hy);
				final_norm = norm & 64'hFFFF_FFFF;
				if (method == METHOD_ACCUM)
					add_to_sum(norm / longint'(frames + 1));
				else if (method != METHOD_FINAL)
					add_to_sum(vec_len((ox - prev_ox) - (hx - prev_hx),
						(oy - prev_oy) - (hy - prev_hy)));
				// previous flows are kept at 25 bits, as in the block
				prev_ox = longint'($signed(25'(ox))); prev_oy = longint'($signed(25'(oy)));
				prev_hx = longint'($signed(25'(hx))); prev_hy = longint'($signed(25'(hy)));
				frames++;
			end
		end else if (op == OP_CLOSE) begin
			if (method == METHOD_ACCUM) dist_v = dist_sum;
			else if (span == 0) begin
				dist_v = 64'h7FFF_FFFF;
				reject = 1;
			end else if (method == METHOD_FINAL) dist_v = final_norm / span;
			else dist_v = dist_sum / span;
			if (dist_v > 64'h7FFF_FFFF) dist_v = 64'h7FFF_FFFF;
			r.distance = dist_v[30:0];
			if (reject || dist_v > threshold) r.verdict = V_REJECT;
			else if (own_len < oth_len) r.verdict = V_OTHER;
			else if (own_len > oth_len) r.verdict = V_OWN;
			else if (own_err > oth_err) r.verdict = V_OTHER;
			else if (own_err < oth_err) r.verdict = V_OWN;
			else r.verdict = V_EQUAL;
			rank_queue.push_back(r);
			clear_span();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rank_t exp_r;
		int    new_errors;
		if (!arst_n) begin
			method <= METHOD_ADJ;
			threshold <= 31'd256;
			base_ox = 0; base_oy = 0; base_hx = 0; base_hy = 0;
			clear_span();
			rank_queue.delete();
			error_count <= 0;
			pending_count <= 0;
		end else begin
			new_errors = 0;
			if (cfg_wr_en) begin
				if (cfg_index == CFG_METHOD) method <= cfg_data[1:0];
				else threshold <= cfg_data;
			end
			if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (rank_queue.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual dist %0h verdict %0d",
						$time, m_tdata[30:0], m_tuser);
					new_errors++;
				end else begin
					exp_r = rank_queue.pop_front();
					if (m_tdata[30:0] !== exp_r.distance || m_tdata[31] !== 1'b0) begin
						$display("%0t: distance mismatch: expected %0h, actual %0h",
							$time, exp_r.distance, m_tdata);
						new_errors++;
					end
					if (m_tuser !== exp_r.verdict) begin
						$display("%0t: verdict mismatch: expected %0d, actual %0d",
							$time, exp_r.verdict, m_tuser);
						new_errors++;
					end
				end
			end
			error_count <= error_count + new_errors;
			pending_count <= rank_queue.size();
		end
	end

endmodule

`default_nettype wire

>>> verif/trajectory_distance_rank_core_tb.sv
// Testbench top for the trajectory distance rank core: clock, reset, stimulus
// and verdict. Depends on tdr_pkg, the core and trajectory_distance_rank_checker.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_distance_rank_core_tb;
	import tdr_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [183:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_wr_en;
	logic         cfg_index;
	logic [30:0]  cfg_data;
	int           error_count;
	int           pending_count;

	// Receiver control: a long hold-off is requested by the stimulus and
	// counted out in the receiver's own process.
	bit           hold_request;
	bit           hold_active;

	trajectory_distance_rank_core u_top (.*);

	trajectory_distance_rank_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("trajectory_distance_rank_core_tb: done, errors");
		$finish;
	end

	// Receiver stall pattern: stretches of random length, stalling with a
	// probability that itself changes from stretch to stretch (including zero).
	initial begin
		int stretch;
		int stall_pct;
		int hold_cycles;
		m_tready = 1'b0;
		hold_active = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_active = 1'b1;
				hold_cycles = 3000;
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_active = 1'b0;
				wait (!hold_request);
			end
			stretch = $urandom_range(5, 80);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			repeat (stretch) begin
				@(posedge clk);
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
				if (hold_request) break;
			end
		end
	end

	// Sender state for bursts and gaps.
	int burst_left;

	function automatic logic [23:0] rand_flow();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'(int'($urandom_range(0, 2048)) - 1024);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] rand_len();
		return ($urandom_range(0, 7) == 0) ? 7'($urandom_range(65, 127))
			: 7'($urandom_range(0, 64));
	endfunction

	function automatic logic [30:0] rand_err();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 3));
			1: return 31'h7FFFFFFF;
			default: return 31'($urandom);
		endcase
	endfunction

	// One transaction on the input channel; gaps come between bursts.
	task automatic send_item(logic [1:0] op, logic [183:0] d);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	function automatic logic [183:0] pack_item(logic [23:0] odx, logic [23:0] ody,
		logic [23:0] hdx, logic [23:0] hdy, logic [6:0] span,
		logic [6:0] own_len, logic [6:0] oth_len, logic [30:0] own_err,
		logic [30:0] oth_err);
		return {5'd0, oth_err, own_err, oth_len, own_len, span, hdy, hdx, ody, odx};
	endfunction

	task automatic send_random_item(logic [1:0] op);
		send_item(op, pack_item(rand_flow(), rand_flow(), rand_flow(), rand_flow(),
			rand_len(), rand_len(), rand_len(), rand_err(), rand_err()));
	endtask

	// Close item with a chosen span and random ranking fields; lengths and
	// errors are often equal so every verdict shows up.
	task automatic send_close(logic [6:0] span);
		logic [6:0]  l0, l1;
		logic [30:0] e0, e1;
		l0 = rand_len();
		l1 = ($urandom_range(0, 1)) ? l0 : rand_len();
		e0 = rand_err();
		e1 = ($urandom_range(0, 1)) ? e0 : rand_err();
		send_item(OP_CLOSE, pack_item(rand_flow(), rand_flow(), rand_flow(),
			rand_flow(), span, l0, l1, e0, e1));
	endtask

	// Drain: drop valid, wait for every expected result, then allow the
	// longest frame item to finish before anything touches the registers.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [30:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One trajectory pair: an optional baseline, a run of frames, a close.
	task automatic send_span();
		int n;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
		if ($urandom_range(0, 3) != 0) send_random_item(OP_BASE);
		repeat (n) send_random_item(OP_FRAME);
		send_close(($urandom_range(0, 9) == 0) ? 7'd0 : rand_len());
	endtask

	initial begin
		logic [30:0] thresholds[4];
		int items;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_BASE;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_METHOD;
		cfg_data = '0;
		hold_request = 1'b0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings first, then extremes of every field.
		send_item(OP_FRAME, pack_item(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
			7'd0, 7'd0, 7'd0, 31'd0, 31'd0));
		send_close(7'd1);
		send_item(OP_BASE, pack_item(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			7'd127, 7'd127, 7'd127, 31'h7FFFFFFF, 31'h7FFFFFFF));
		send_item(OP_FRAME, pack_item(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
			7'd127, 7'd127, 7'd127, 31'h7FFFFFFF, 31'h7FFFFFFF));
		send_close(7'd0);
		send_item(OP_UNUSED, {184{1'b1}});
		send_item(OP_CLOSE, pack_item(24'd0, 24'd0, 24'd0, 24'd0, 7'd1, 7'd5, 7'd5,
			31'd7, 31'd7));
		send_item(OP_CLOSE, pack_item(24'd0, 24'd0, 24'd0, 24'd0, 7'd1, 7'd5, 7'd9,
			31'd7, 31'd7));
		send_item(OP_CLOSE, pack_item(24'd0, 24'd0, 24'd0, 24'd0, 7'd1, 7'd9, 7'd5,
			31'd7, 31'd7));
		send_item(OP_CLOSE, pack_item(24'd0, 24'd0, 24'd0, 24'd0, 7'd1, 7'd5, 7'd5,
			31'd9, 31'd7));
		send_item(OP_CLOSE, pack_item(24'd0, 24'd0, 24'd0, 24'd0, 7'd1, 7'd5, 7'd5,
			31'd7, 31'd9));
		drain();
		// Frames past capacity in the accumulated method, with extreme flows.
		write_reg(CFG_METHOD, 31'(METHOD_ACCUM));
		write_reg(CFG_THRESHOLD, 31'h7FFFFFFF);
		send_item(OP_BASE, '0);
		repeat (68) send_item(OP_FRAME, pack_item(24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			24'h800000, 7'd0, 7'd0, 7'd0, 31'd0, 31'd0));
		send_close(7'd0);
		drain();
		write_reg(CFG_METHOD, 31'(METHOD_FINAL));
		write_reg(CFG_THRESHOLD, 31'd0);
		send_item(OP_FRAME, pack_item(24'd100, 24'd0, 24'd0, 24'd0, 7'd0, 7'd0, 7'd0,
			31'd0, 31'd0));
		send_close(7'd3);
		send_close(7'd1);
		drain();

		// Random phases across methods (three included) and thresholds.
		thresholds = '{31'd0, 31'd256, 31'h7FFFFFFF, 31'd20000};
		items = 0;
		for (int phase = 0; phase < 12; phase++) begin
			write_reg(CFG_METHOD, 31'(phase % 4));
			write_reg(CFG_THRESHOLD, ($urandom_range(0, 1)) ?
				thresholds[$urandom_range(0, 3)] : 31'($urandom));
			if (phase == 5) begin
				// Long receiver hold-off while the sender keeps offering closes.
				hold_request = 1'b1;
				wait (hold_active);
				hold_request = 1'b0;
				repeat (12) send_close(7'd1);
			end
			repeat (13) begin
				if ($urandom_range(0, 9) == 0) send_random_item(2'($urandom_range(0, 3)));
				else send_span();
			end
			drain();
		end

		repeat (400) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("trajectory_distance_rank_core_tb: done, clean");
		else
			$display("trajectory_distance_rank_core_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hdl/tdr_pkg.sv
hdl/tdr_isqrt.sv
hdl/tdr_div.sv
hdl/trajectory_distance_rank_core.sv
verif/trajectory_distance_rank_checker.sv
verif/trajectory_distance_rank_core_tb.sv
